// ===== src/lkmc_pkg.sv =====
package lkmc_pkg;

   localparam int KEY_MAX_BYTES = 16;
   localparam int KEY_LEN_W     = $clog2(KEY_MAX_BYTES + 1);
   localparam int KEY_BITS      = 8 * KEY_MAX_BYTES;
   localparam int RSP_DEPTH     = 4;
   localparam int RSP_PTR_W     = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W     = $clog2(RSP_DEPTH + 1);

   localparam logic [7:0]           NEWLINE_BYTE = 8'd10;
   localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX  = KEY_LEN_W'(KEY_MAX_BYTES);
   localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST  = KEY_LEN_W'(1);
   localparam logic [31:0]          LINE_FIRST   = 32'd1;

   typedef enum logic [1:0] {
      CSR_KEY_LOW  = 2'd0,
      CSR_KEY_HIGH = 2'd1,
      CSR_KEY_LEN  = 2'd2,
      CSR_COUNT_EN = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_LINE = 1'b0,
      KIND_FILE = 1'b1
   } result_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_file;
   } req_payload_type;

   typedef struct packed {
      result_kind_type result_kind;
      logic [31:0]     line_number;
      logic [31:0]     match_count;
      logic            last_result;
   } rsp_payload_type;

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

endpackage

// ===== src/line_keyword_match_counter.sv =====
// Counts non-overlapping, leftmost-first occurrences of a 1 to 16 byte keyword
// in each newline-delimited line of a byte stream. A line with at least one hit
// gives a result with its 1-based line number and count; an item with
// end_of_file closes any open line and, when count_enable is set, adds a
// file-total result, then line and file state return to their start values.
// One item is taken every clock while req_stall is low: the keyword compare and
// counter updates run in the cycle of the transfer, and results go into a
// four-entry result queue. An item gives zero, one or two results; req_stall
// rises while the queue has fewer than two free entries, so one item per cycle
// is sustained as long as the result side takes results as fast as they are
// made. A result is written into the queue registers with its item and appears on
// rsp_ from there, later when results queued ahead of it are still waiting. Write
// configuration only while the block is idle.
module line_keyword_match_counter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lkmc_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lkmc_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  lkmc_pkg::csr_index_type   csr_index,
   input  logic [63:0]               csr_data
);
   import lkmc_pkg::*;

   // configuration
   logic [63:0]          key_low_ff;
   logic [63:0]          key_high_ff;
   logic [KEY_LEN_W-1:0] key_len_ff;
   logic                 count_en_ff;

   // line and file state
   logic [7:0]           recent_ff [KEY_MAX_BYTES];
   logic [7:0]           recent_in [KEY_MAX_BYTES];
   logic [KEY_LEN_W-1:0] line_bytes_ff, line_bytes_in;
   logic [KEY_LEN_W-1:0] since_match_ff, since_match_in;
   logic [31:0]          current_line_ff, current_line_in;
   logic [31:0]          line_matches_ff, line_matches_in;
   logic [31:0]          file_matches_ff, file_matches_in;
   logic                 line_open_ff, line_open_in;

   // result queue
   rsp_payload_type      rsp_mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                 req_fire;
   logic                 rsp_fire;
   logic [KEY_BITS-1:0]  key_all;
   logic [KEY_LEN_W-1:0] len_eff;
   logic [KEY_LEN_W-1:0] line_bytes_inc;
   logic [KEY_LEN_W-1:0] since_match_inc;
   logic [7:0]           window [KEY_MAX_BYTES];
   logic [7:0]           key_sel [KEY_MAX_BYTES];
   logic                 hit;
   logic                 is_newline;
   logic                 line_res;
   logic                 file_res;
   logic [31:0]          line_res_num;
   logic [31:0]          line_res_cnt;
   logic [31:0]          total_cnt;
   rsp_payload_type      res0;
   rsp_payload_type      res1;
   logic [1:0]           push_cnt;

   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign csr_ready = 1'b1;
   assign req_stall = rsp_count_ff > RSP_CNT_W'(RSP_DEPTH - 2);
   assign rsp_valid   = rsp_count_ff != '0;
   assign rsp_payload = rsp_mem_ff[rd_ptr_ff];

   assign key_all    = {key_high_ff, key_low_ff};
   assign len_eff    = (key_len_ff > KEY_LEN_MAX) ? KEY_LEN_MAX : key_len_ff;
   assign is_newline = req_payload.has_byte && (req_payload.data_byte == NEWLINE_BYTE);
   assign line_bytes_inc  = (line_bytes_ff < KEY_LEN_MAX) ? line_bytes_ff + 1'b1
                                                          : line_bytes_ff;
   assign since_match_inc = (since_match_ff < KEY_LEN_MAX) ? since_match_ff + 1'b1
                                                           : since_match_ff;

   // window after the new byte shifts in; position j pairs with keyword byte len-1-j
   always_comb begin
      logic [KEY_LEN_W-1:0] kidx;
      for (int j = 0; j < KEY_MAX_BYTES; j++) begin
         window[j] = (j == 0) ? req_payload.data_byte : recent_ff[(j == 0) ? 0 : j - 1];
         kidx = len_eff - KEY_LEN_W'(1) - KEY_LEN_W'(j);
         key_sel[j] = key_all[kidx[KEY_LEN_W-2:0]*8 +: 8];
      end
   end

   always_comb begin
      hit = (len_eff != '0) && (line_bytes_inc >= len_eff) && (since_match_inc >= len_eff);
      for (int j = 0; j < KEY_MAX_BYTES; j++) begin
         if ((KEY_LEN_W'(j) < len_eff) && (window[j] != key_sel[j])) begin
            hit = 1'b0;
         end
      end
   end

   always_comb begin
      recent_in       = recent_ff;
      line_bytes_in   = line_bytes_ff;
      since_match_in  = since_match_ff;
      current_line_in = current_line_ff;
      line_matches_in = line_matches_ff;
      file_matches_in = file_matches_ff;
      line_open_in    = line_open_ff;
      line_res        = 1'b0;
      line_res_num    = current_line_ff;
      line_res_cnt    = line_matches_ff;

      if (is_newline) begin
         line_res        = line_matches_ff != '0;
         file_matches_in = sat_add32(file_matches_ff, line_matches_ff);
         current_line_in = sat_add32(current_line_ff, 32'd1);
         line_bytes_in   = '0;
         since_match_in  = KEY_LEN_MAX;
         line_matches_in = '0;
         line_open_in    = 1'b0;
      end else if (req_payload.has_byte) begin
         for (int j = 0; j < KEY_MAX_BYTES; j++) begin
            recent_in[j] = window[j];
         end
         line_open_in    = 1'b1;
         line_bytes_in   = line_bytes_inc;
         since_match_in  = hit ? '0 : since_match_inc;
         line_matches_in = hit ? sat_add32(line_matches_ff, 32'd1) : line_matches_ff;
      end

      // line_matches is zero whenever no line is open, so one sum serves both cases
      total_cnt = sat_add32(file_matches_in, line_matches_in);
      file_res  = req_payload.end_of_file && count_en_ff;

      if (req_payload.end_of_file) begin
         if (line_open_in && (line_matches_in != '0)) begin
            line_res     = 1'b1;
            line_res_num = current_line_in;
            line_res_cnt = line_matches_in;
         end
         for (int j = 0; j < KEY_MAX_BYTES; j++) begin
            recent_in[j] = '0;
         end
         line_bytes_in   = '0;
         since_match_in  = KEY_LEN_MAX;
         current_line_in = LINE_FIRST;
         line_matches_in = '0;
         file_matches_in = '0;
         line_open_in    = 1'b0;
      end
   end

   always_comb begin
      rsp_payload_type file_item;
      file_item.result_kind = KIND_FILE;
      file_item.line_number = '0;
      file_item.match_count = total_cnt;
      file_item.last_result = 1'b1;

      if (line_res) begin
         res0.result_kind = KIND_LINE;
         res0.line_number = line_res_num;
         res0.match_count = line_res_cnt;
         res0.last_result = !file_res;
      end else begin
         res0 = file_item;
      end
      res1     = file_item;
      push_cnt = req_fire ? ({1'b0, line_res} + {1'b0, file_res}) : 2'd0;
   end

   assign wr_ptr_in    = wr_ptr_ff + RSP_PTR_W'(push_cnt);
   assign rd_ptr_in    = rd_ptr_ff + RSP_PTR_W'(rsp_fire);
   assign rsp_count_in = rsp_count_ff + RSP_CNT_W'(push_cnt) - RSP_CNT_W'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= KEY_LEN_RST;
         count_en_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            CSR_KEY_LEN:  key_len_ff  <= csr_data[KEY_LEN_W-1:0];
            CSR_COUNT_EN: count_en_ff <= csr_data[0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < KEY_MAX_BYTES; j++) begin
            recent_ff[j] <= '0;
         end
         line_bytes_ff   <= '0;
         since_match_ff  <= KEY_LEN_MAX;
         current_line_ff <= LINE_FIRST;
         line_matches_ff <= '0;
         file_matches_ff <= '0;
         line_open_ff    <= 1'b0;
      end else if (req_fire) begin
         recent_ff       <= recent_in;
         line_bytes_ff   <= line_bytes_in;
         since_match_ff  <= since_match_in;
         current_line_ff <= current_line_in;
         line_matches_ff <= line_matches_in;
         file_matches_ff <= file_matches_in;
         line_open_ff    <= line_open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         rsp_count_ff <= '0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         rsp_mem_ff[wr_ptr_ff] <= res0;
      end
      if (push_cnt == 2'd2) begin
         rsp_mem_ff[wr_ptr_ff + 1'b1] <= res1;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue overfilled");

   assert property (@(posedge clock) disable iff (reset)
      (line_matches_ff != '0) |-> line_open_ff)
      else $error("line matches counted with no open line");

   assert property (@(posedge clock) disable iff (reset)
      (line_bytes_ff <= KEY_LEN_MAX) && (since_match_ff <= KEY_LEN_MAX))
      else $error("byte counters beyond keyword window");

   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.end_of_file) |=>
         (current_line_ff == LINE_FIRST) && (file_matches_ff == '0) && !line_open_ff)
      else $error("file state not restored after end of file");

   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.end_of_file && count_en_ff) |=> rsp_valid)
      else $error("file total missing after end of file");

endmodule

// ===== bench/line_keyword_match_counter_tb.sv =====
module line_keyword_match_counter_tb;
   import lkmc_pkg::*;

   class keyword_count_tracker;
      logic [63:0]     key_low;
      logic [63:0]     key_high;
      logic [4:0]      key_len;
      logic            count_en;
      logic [7:0]      history [KEY_MAX_BYTES];
      int unsigned     line_bytes;
      int unsigned     since_hit;
      logic [31:0]     line_no;
      logic [31:0]     line_hits;
      logic [31:0]     file_hits;
      bit              line_open;
      rsp_payload_type staged [$];
      rsp_payload_type pending_results [$];
      int              errors;

      function new();
         key_low  = '0;
         key_high = '0;
         key_len  = KEY_LEN_RST;
         count_en = 1'b0;
         errors   = 0;
         start_file();
      endfunction

      function logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
         logic [32:0] sum;
         sum = {1'b0, a} + {1'b0, b};
         if (sum[32])
            return 32'hFFFF_FFFF;
         return sum[31:0];
      endfunction

      function void start_line();
         line_bytes = 0;
         since_hit  = KEY_MAX_BYTES;
         line_hits  = '0;
         line_open  = 1'b0;
      endfunction

      function void start_file();
         foreach (history[i])
            history[i] = '0;
         start_line();
         line_no   = LINE_FIRST;
         file_hits = '0;
      endfunction

      function void write_reg(input csr_index_type sel, input logic [63:0] value);
         case (sel)
            CSR_KEY_LOW:  key_low  = value;
            CSR_KEY_HIGH: key_high = value;
            CSR_KEY_LEN:  key_len  = value[4:0];
            CSR_COUNT_EN: count_en = value[0];
            default: ;
         endcase
      endfunction

      function void close_line();
         rsp_payload_type r;
         if (line_hits != 0) begin
            r.result_kind = KIND_LINE;
            r.line_number = line_no;
            r.match_count = line_hits;
            r.last_result = 1'b0;
            staged.insert(staged.size(), r);
         end
         file_hits = add_sat(file_hits, line_hits);
         line_no   = add_sat(line_no, 32'd1);
         start_line();
      endfunction

      function void take_byte(input logic [7:0] b);
         logic [127:0] keyword;
         int unsigned  span;
         bit           hit;
         keyword = {key_high, key_low};
         span = (key_len > KEY_LEN_MAX) ? KEY_MAX_BYTES : key_len;
         for (int i = KEY_MAX_BYTES - 1; i > 0; i--)
            history[i] = history[i-1];
         history[0] = b;
         line_open = 1'b1;
         if (line_bytes < KEY_MAX_BYTES)
            line_bytes++;
         if (since_hit < KEY_MAX_BYTES)
            since_hit++;
         // newest byte sits at 0, so keyword byte i lines up with span-1-i
         hit = (span > 0) && (line_bytes >= span) && (since_hit >= span);
         for (int i = 0; i < span; i++) begin
            if (history[span-1-i] != keyword[8*i +: 8])
               hit = 1'b0;
         end
         if (hit) begin
            line_hits = add_sat(line_hits, 32'd1);
            since_hit = 0;
         end
      endfunction

      function void take_request(input req_payload_type p);
         rsp_payload_type r;
         if (p.has_byte) begin
            if (p.data_byte == NEWLINE_BYTE)
               close_line();
            else
               take_byte(p.data_byte);
         end
         if (p.end_of_file) begin
            if (line_open)
               close_line();
            if (count_en) begin
               r.result_kind = KIND_FILE;
               r.line_number = '0;
               r.match_count = add_sat(file_hits, line_hits);
               r.last_result = 1'b0;
               staged.insert(staged.size(), r);
            end
            start_file();
         end
         foreach (staged[i]) begin
            r = staged[i];
            r.last_result = (i == staged.size() - 1);
            pending_results.insert(pending_results.size(), r);
         end
         staged.delete();
      endfunction

      task report(input string what);
         errors++;
         if (errors <= 50)
            $display("mismatch: %s", what);
      endtask

      task check_result(input rsp_payload_type got);
         rsp_payload_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result kind %0d line %0d count %0d",
                             got.result_kind, got.line_number, got.match_count));
            return;
         end
         want = pending_results.pop_front();
         if (got.result_kind !== want.result_kind)
            report($sformatf("result_kind got %0d, expected %0d",
                             got.result_kind, want.result_kind));
         if (got.line_number !== want.line_number)
            report($sformatf("line_number got %0d, expected %0d",
                             got.line_number, want.line_number));
         if (got.match_count !== want.match_count)
            report($sformatf("match_count got %0d, expected %0d (line %0d)",
                             got.match_count, want.match_count, want.line_number));
         if (got.last_result !== want.last_result)
            report($sformatf("last_result got %0d, expected %0d (line %0d)",
                             got.last_result, want.last_result, want.line_number));
      endtask
   endclass

   localparam int         CLOCK_PERIOD     = 8;
   localparam int         RUN_LIMIT_CYCLES = 200000;
   localparam int         SETTLE_CYCLES    = 12;
   localparam int         PHASE_COUNT      = 8;
   localparam logic [7:0] CHAR_A           = 8'h61;

   logic            clock;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid   = 1'b0;
   logic            csr_ready;
   csr_index_type   csr_index   = CSR_KEY_LOW;
   logic [63:0]     csr_data    = '0;

   int unsigned          send_idle_pct = 0;
   int unsigned          recv_idle_pct = 0;
   int unsigned          items_sent    = 0;
   keyword_count_tracker tracker;

   line_keyword_match_counter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLOCK_PERIOD * RUN_LIMIT_CYCLES);
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result(rsp_payload);
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   task automatic configure(input logic [127:0] key, input logic [4:0] len, input logic en);
      logic [63:0]   value;
      csr_index_type sel;
      for (int idx = 0; idx < 4; idx++) begin
         sel = csr_index_type'(idx);
         case (sel)
            CSR_KEY_LOW:  value = key[63:0];
            CSR_KEY_HIGH: value = key[127:64];
            CSR_KEY_LEN:  value = {59'd0, len};
            default:      value = {63'd0, en};
         endcase
         csr_valid <= 1'b1;
         csr_index <= sel;
         csr_data  <= value;
         do @(posedge clock); while (!csr_ready);
         tracker.write_reg(sel, value);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic send(input logic [7:0] data, input logic has, input logic eof);
      req_payload_type p;
      p.data_byte   = data;
      p.has_byte    = has;
      p.end_of_file = eof;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      tracker.take_request(p);
      if (has || eof)
         items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int ph);
      logic [7:0]   letters [3];
      logic [127:0] key;
      logic [4:0]   len;
      int unsigned  span;
      int unsigned  stop_at;
      int unsigned  pick;
      case (ph)
         0:       len = 5'd1;
         1:       len = 5'd16;
         2:       len = 5'd3;
         4:       len = 5'd20;
         5:       len = 5'd2;
         6:       len = 5'd0;
         default: len = 5'($urandom_range(1, 16));
      endcase
      span = (len > KEY_LEN_MAX) ? KEY_MAX_BYTES : len;
      foreach (letters[i]) begin
         do letters[i] = 8'($urandom_range(255)); while (letters[i] == NEWLINE_BYTE);
      end
      // unused key bytes are random so every bit of the key registers toggles
      for (int i = 0; i < KEY_MAX_BYTES; i++)
         key[8*i +: 8] = (i < span) ? letters[$urandom_range(2)] : 8'($urandom_range(255));
      configure(key, len, (ph % 3) != 0);
      stop_at = items_sent + ((len == 0) ? 60 : 180);
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 12) begin
            send(8'($urandom_range(255)), 1'($urandom_range(1)), $urandom_range(19) == 0);
         end else begin
            repeat ($urandom_range(4)) begin
               if ($urandom_range(99) < 45) begin
                  for (int k = 0; k < span; k++)
                     send(key[8*k +: 8], 1'b1, 1'b0);
               end else begin
                  repeat ($urandom_range(1, 4))
                     send(letters[$urandom_range(2)], 1'b1, 1'b0);
               end
               if ($urandom_range(99) < 5)
                  send(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            pick = $urandom_range(99);
            if (pick < 85)
               send(NEWLINE_BYTE, 1'b1, 1'b0);
            else if (pick < 90)
               send(8'($urandom_range(255)), 1'b0, 1'b1);
            else if (pick < 95)
               send(NEWLINE_BYTE, 1'b1, 1'b1);
            else
               send(letters[$urandom_range(2)], 1'b1, 1'b1);
         end
      end
      send(8'h00, 1'b0, 1'b1);
      drain();
   endtask

   initial begin
      tracker = new();
      send_idle_pct = 28;
      recv_idle_pct = 60;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // keyword "aa": overlapping occurrence in a run of four is skipped
      configure({112'd0, CHAR_A, CHAR_A}, 5'd2, 1'b1);
      repeat (4) send(CHAR_A, 1'b1, 1'b0);
      send(NEWLINE_BYTE, 1'b1, 1'b0);
      send(NEWLINE_BYTE, 1'b1, 1'b0);
      send(8'hFF, 1'b1, 1'b0);
      send(8'h00, 1'b1, 1'b0);
      send(8'hA5, 1'b0, 1'b0);
      send(CHAR_A, 1'b1, 1'b0);
      // end of file on a byte closes the open line, then the file total
      send(CHAR_A, 1'b1, 1'b1);
      // end of file alone on an empty file: total only
      send(8'h00, 1'b0, 1'b1);
      send(CHAR_A, 1'b1, 1'b0);
      send(CHAR_A, 1'b1, 1'b0);
      send(NEWLINE_BYTE, 1'b1, 1'b1);
      drain();

      // zero keyword length never matches
      configure({112'd0, CHAR_A, CHAR_A}, 5'd0, 1'b1);
      send(CHAR_A, 1'b1, 1'b0);
      send(CHAR_A, 1'b1, 1'b0);
      send(NEWLINE_BYTE, 1'b1, 1'b0);
      send(CHAR_A, 1'b0, 1'b1);
      drain();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         if (ph == 3) begin
            send_idle_pct = 60;
            recv_idle_pct = 28;
         end else if (ph == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         run_phase(ph);
      end

      if (tracker.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

// ===== sim.f =====
src/lkmc_pkg.sv
src/line_keyword_match_counter.sv
bench/line_keyword_match_counter_tb.sv
